/* rtl/nearest_ray_triangle_hit_defines.svh */
// assertion macros used by the back end of the nearest ray/triangle hit rtl
`ifndef NEAREST_RAY_TRIANGLE_HIT_DEFINES_SVH
`define NEAREST_RAY_TRIANGLE_HIT_DEFINES_SVH

// same-cycle implication, checked on clk, off while in reset
`define NRTH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while in reset
`define NRTH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nrth_pkg.sv */
// types, widths and the multiply program of the nearest ray/triangle hit block
package nrth_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIR_WIDTH   = 16;
    localparam int DIR_FRAC    = DIR_WIDTH - 2;
    localparam int QB          = COORD_WIDTH - 1;
    localparam int EW          = COORD_WIDTH + 1;
    localparam int PW          = DIR_WIDTH + EW + 1;
    localparam int QW          = 2 * EW + 1;
    localparam int BW          = (EW > DIR_WIDTH) ? EW : DIR_WIDTH;
    localparam int DIG         = 17;
    localparam int ND_DIR      = (DIR_WIDTH + DIG - 1) / DIG;
    localparam int ND_T        = (EW + DIG - 1) / DIG;
    localparam int ND_P        = (PW + DIG - 1) / DIG;
    localparam int ND_Q        = (QW + DIG - 1) / DIG;
    localparam int NDIG_MAX    = (ND_P > ND_Q) ? ND_P : ND_Q;
    localparam int AW          = NDIG_MAX * DIG;
    localparam int CW          = $clog2(NDIG_MAX);
    localparam int ACCW        = ((QW > PW) ? QW : PW) + BW + 2;
    localparam int SHMAX       = (QB > DIR_FRAC) ? QB : DIR_FRAC;
    localparam int DVW         = ACCW + SHMAX;
    localparam int DCW         = $clog2(QB + 1);
    localparam int PRW         = DIR_WIDTH + QB + 1;
    localparam int SUMW        = ((PRW + 1 > COORD_WIDTH) ? PRW + 1 : COORD_WIDTH) + 1;
    localparam int CFG_IW      = 3;
    localparam int NSTEP       = 24;
    localparam int STEP_W      = 5;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_MAX_DIST = 3'd6;

    // multiplicand sources
    localparam logic [3:0] A_D0 = 4'd0;
    localparam logic [3:0] A_D1 = 4'd1;
    localparam logic [3:0] A_D2 = 4'd2;
    localparam logic [3:0] A_T0 = 4'd3;
    localparam logic [3:0] A_T1 = 4'd4;
    localparam logic [3:0] A_T2 = 4'd5;
    localparam logic [3:0] A_P0 = 4'd6;
    localparam logic [3:0] A_P1 = 4'd7;
    localparam logic [3:0] A_P2 = 4'd8;
    localparam logic [3:0] A_Q0 = 4'd9;
    localparam logic [3:0] A_Q1 = 4'd10;
    localparam logic [3:0] A_Q2 = 4'd11;

    // multiplier sources
    localparam logic [3:0] B_E1_0 = 4'd0;
    localparam logic [3:0] B_E1_1 = 4'd1;
    localparam logic [3:0] B_E1_2 = 4'd2;
    localparam logic [3:0] B_E2_0 = 4'd3;
    localparam logic [3:0] B_E2_1 = 4'd4;
    localparam logic [3:0] B_E2_2 = 4'd5;
    localparam logic [3:0] B_T0   = 4'd6;
    localparam logic [3:0] B_T1   = 4'd7;
    localparam logic [3:0] B_T2   = 4'd8;
    localparam logic [3:0] B_D0   = 4'd9;
    localparam logic [3:0] B_D1   = 4'd10;
    localparam logic [3:0] B_D2   = 4'd11;

    // accumulator destinations
    localparam logic [3:0] DST_P0 = 4'd0;
    localparam logic [3:0] DST_P1 = 4'd1;
    localparam logic [3:0] DST_P2 = 4'd2;
    localparam logic [3:0] DST_Q0 = 4'd3;
    localparam logic [3:0] DST_Q1 = 4'd4;
    localparam logic [3:0] DST_Q2 = 4'd5;
    localparam logic [3:0] DST_D  = 4'd6;
    localparam logic [3:0] DST_U  = 4'd7;
    localparam logic [3:0] DST_V  = 4'd8;
    localparam logic [3:0] DST_T  = 4'd9;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
        logic                          last_triangle;
    } tri_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] hit_x;
        logic signed [COORD_WIDTH-1:0] hit_y;
        logic signed [COORD_WIDTH-1:0] hit_z;
    } res_t;

    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] org;
        logic [2:0][DIR_WIDTH-1:0]   dir;
        logic [QB-1:0]               max_dist;
    } ray_t;

    typedef struct packed {
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        logic [2:0][EW-1:0] t0;
        logic               last;
    } qent_t;

    typedef struct packed {
        logic          go;
        logic          clear;
        logic          neg;
        logic [CW-1:0] last_idx;
    } mac_req_t;

    typedef struct packed {
        logic          busy;
        logic          ovf;
        logic [QB-1:0] quo;
    } div_res_t;

    typedef struct packed {
        logic [3:0] asel;
        logic [3:0] bsel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dst;
    } prog_t;

    function automatic prog_t mk(input logic [3:0] asel, input logic [3:0] bsel,
                                 input logic neg, input logic first, input logic last,
                                 input logic [3:0] dst);
        prog_t r;
        r.asel  = asel;
        r.bsel  = bsel;
        r.neg   = neg;
        r.first = first;
        r.last  = last;
        r.dst   = dst;
        return r;
    endfunction

    // p = dir x e2, q = t0 x e1, then D = e1.p, U = t0.p, V = dir.q, T = e2.q
    function automatic prog_t prog_at(input logic [STEP_W-1:0] i);
        prog_t r;
        r = mk(A_D0, B_E1_0, 1'b0, 1'b1, 1'b1, DST_P0);
        case (i)
            5'd0:  r = mk(A_D1, B_E2_2, 1'b0, 1'b1, 1'b0, DST_P0);
            5'd1:  r = mk(A_D2, B_E2_1, 1'b1, 1'b0, 1'b1, DST_P0);
            5'd2:  r = mk(A_D2, B_E2_0, 1'b0, 1'b1, 1'b0, DST_P1);
            5'd3:  r = mk(A_D0, B_E2_2, 1'b1, 1'b0, 1'b1, DST_P1);
            5'd4:  r = mk(A_D0, B_E2_1, 1'b0, 1'b1, 1'b0, DST_P2);
            5'd5:  r = mk(A_D1, B_E2_0, 1'b1, 1'b0, 1'b1, DST_P2);
            5'd6:  r = mk(A_T1, B_E1_2, 1'b0, 1'b1, 1'b0, DST_Q0);
            5'd7:  r = mk(A_T2, B_E1_1, 1'b1, 1'b0, 1'b1, DST_Q0);
            5'd8:  r = mk(A_T2, B_E1_0, 1'b0, 1'b1, 1'b0, DST_Q1);
            5'd9:  r = mk(A_T0, B_E1_2, 1'b1, 1'b0, 1'b1, DST_Q1);
            5'd10: r = mk(A_T0, B_E1_1, 1'b0, 1'b1, 1'b0, DST_Q2);
            5'd11: r = mk(A_T1, B_E1_0, 1'b1, 1'b0, 1'b1, DST_Q2);
            5'd12: r = mk(A_P0, B_E1_0, 1'b0, 1'b1, 1'b0, DST_D);
            5'd13: r = mk(A_P1, B_E1_1, 1'b0, 1'b0, 1'b0, DST_D);
            5'd14: r = mk(A_P2, B_E1_2, 1'b0, 1'b0, 1'b1, DST_D);
            5'd15: r = mk(A_P0, B_T0,   1'b0, 1'b1, 1'b0, DST_U);
            5'd16: r = mk(A_P1, B_T1,   1'b0, 1'b0, 1'b0, DST_U);
            5'd17: r = mk(A_P2, B_T2,   1'b0, 1'b0, 1'b1, DST_U);
            5'd18: r = mk(A_Q0, B_D0,   1'b0, 1'b1, 1'b0, DST_V);
            5'd19: r = mk(A_Q1, B_D1,   1'b0, 1'b0, 1'b0, DST_V);
            5'd20: r = mk(A_Q2, B_D2,   1'b0, 1'b0, 1'b1, DST_V);
            5'd21: r = mk(A_Q0, B_E2_0, 1'b0, 1'b1, 1'b0, DST_T);
            5'd22: r = mk(A_Q1, B_E2_1, 1'b0, 1'b0, 1'b0, DST_T);
            5'd23: r = mk(A_Q2, B_E2_2, 1'b0, 1'b0, 1'b1, DST_T);
            default: r = mk(A_D0, B_E1_0, 1'b0, 1'b1, 1'b1, DST_P0);
        endcase
        return r;
    endfunction

endpackage

/* rtl/nrth_front.sv */
// front end: accepts triangles, forms edge vectors and queues them
module nrth_front
    import nrth_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  tri_valid,
    output logic  tri_stall,
    input  tri_t  tri_data,
    input  ray_t  ray,
    output logic  q_valid,
    output qent_t q_head,
    input  logic  q_pop
);

    qent_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    qent_t      ent;
    logic       push;

    assign tri_stall = (count_reg == 2'd2);
    assign push      = tri_valid && !tri_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign q_head    = mem_reg[rd_ptr_reg];

    // edges and origin offset, one bit wider than the coordinates
    always_comb
    begin
        ent.e1[0] = EW'(tri_data.b_x) - EW'(tri_data.a_x);
        ent.e1[1] = EW'(tri_data.b_y) - EW'(tri_data.a_y);
        ent.e1[2] = EW'(tri_data.b_z) - EW'(tri_data.a_z);
        ent.e2[0] = EW'(tri_data.c_x) - EW'(tri_data.a_x);
        ent.e2[1] = EW'(tri_data.c_y) - EW'(tri_data.a_y);
        ent.e2[2] = EW'(tri_data.c_z) - EW'(tri_data.a_z);
        ent.t0[0] = EW'($signed(ray.org[0])) - EW'(tri_data.a_x);
        ent.t0[1] = EW'($signed(ray.org[1])) - EW'(tri_data.a_y);
        ent.t0[2] = EW'($signed(ray.org[2])) - EW'(tri_data.a_z);
        ent.last  = tri_data.last_triangle;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/nrth_mac.sv */
// shared multiply-accumulate unit, one 17-bit digit of the multiplicand a cycle
module nrth_mac
    import nrth_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  mac_req_t        req,
    input  logic [AW-1:0]   a,
    input  logic [BW-1:0]   b,
    output logic            busy,
    output logic [ACCW-1:0] acc
);

    logic [AW-1:0]          a_reg;
    logic signed [BW-1:0]   b_reg;
    logic                   neg_reg;
    logic [CW-1:0]          last_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic [ACCW-1:0]        acc_reg;
    logic [DIG-1:0]         dig_raw;
    logic signed [DIG:0]    dig;
    logic signed [DIG+BW:0] prod;
    logic [ACCW-1:0]        ext;
    logic [ACCW-1:0]        term;

    assign busy = busy_reg;
    assign acc  = acc_reg;

    // top digit carries the sign, lower digits are unsigned
    always_comb
    begin
        dig_raw = a_reg[cnt_reg*DIG +: DIG];
        dig     = {(cnt_reg == last_reg) ? dig_raw[DIG-1] : 1'b0, dig_raw};
        prod    = dig * b_reg;
        ext     = ACCW'(prod) << (cnt_reg * DIG);
        term    = neg_reg ? (~ext + ACCW'(1)) : ext;
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            a_reg    <= a;
            b_reg    <= b;
            neg_reg  <= req.neg;
            last_reg <= req.last_idx;
            if (req.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == last_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/nrth_div.sv */
// restoring divider for the hit distance, one quotient bit a cycle
module nrth_div
    import nrth_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  logic [ACCW-1:0] num,
    input  logic [ACCW-1:0] den,
    output div_res_t        res
);

    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] dsh_reg;
    logic [QB-1:0]  quo_reg;
    logic           ovf_reg;
    logic [DCW-1:0] cnt_reg;
    logic           busy_reg;
    logic           ge;

    assign ge       = (rem_reg >= dsh_reg);
    assign res.busy = busy_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

    // first step only checks that the quotient fits
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= DVW'(num) << DIR_FRAC;
            dsh_reg <= DVW'(den) << QB;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                ovf_reg <= ge;
            end
            else
            begin
                quo_reg <= {quo_reg[QB-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DCW'(1);
            if (cnt_reg == DCW'(QB))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/nrth_back.sv */
// back end: intersection sequencer, nearest-hit tracking and result register
`include "nearest_ray_triangle_hit_defines.svh"
module nrth_back
    import nrth_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ray_t  ray,
    input  logic  q_valid,
    input  qent_t q_head,
    output logic  q_pop,
    output logic  res_valid,
    input  logic  res_stall,
    output res_t  res_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ISSUE = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_DIVGO = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_HMUL  = 4'd7;
    localparam logic [3:0] S_HADD  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]                  state_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [1:0]                  k_reg;
    qent_t                       ent_reg;
    logic [2:0][PW-1:0]          p_reg;
    logic [2:0][QW-1:0]          q_reg;
    logic [ACCW-1:0]             dd_reg;
    logic [ACCW-1:0]             uu_reg;
    logic [ACCW-1:0]             vv_reg;
    logic [ACCW-1:0]             tt_reg;
    logic signed [PRW-1:0]       prod_reg;
    logic [2:0][COORD_WIDTH-1:0] hv_reg;
    logic [COORD_WIDTH-1:0]      best_reg;
    logic                        found_reg;
    logic                        res_valid_reg;
    res_t                        res_reg;

    prog_t           op;
    mac_req_t        mac_req;
    logic [AW-1:0]   a_sel;
    logic [BW-1:0]   b_sel;
    logic            mac_busy;
    logic [ACCW-1:0] mac_acc;
    logic            div_req_go;
    div_res_t        div_res;
    logic            accept_tri;
    logic            res_free;
    logic            res_load;
    logic            better;
    logic [SUMW-1:0] rnd;
    logic [SUMW-1:0] hsum;
    logic [COORD_WIDTH-1:0] hsat;

    assign op        = prog_at(step_reg);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_load  = (state_reg == S_EMIT) && res_free;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign div_req_go = (state_reg == S_DIVGO);

    // operand selection and digit count of the multiplicand
    always_comb
    begin
        mac_req.go    = (state_reg == S_ISSUE);
        mac_req.clear = op.first;
        mac_req.neg   = op.neg;
        case (op.asel) inside
            A_D0, A_D1, A_D2: mac_req.last_idx = CW'(ND_DIR - 1);
            A_T0, A_T1, A_T2: mac_req.last_idx = CW'(ND_T - 1);
            A_P0, A_P1, A_P2: mac_req.last_idx = CW'(ND_P - 1);
            default:          mac_req.last_idx = CW'(ND_Q - 1);
        endcase
        case (op.asel)
            A_D0:    a_sel = AW'($signed(ray.dir[0]));
            A_D1:    a_sel = AW'($signed(ray.dir[1]));
            A_D2:    a_sel = AW'($signed(ray.dir[2]));
            A_T0:    a_sel = AW'($signed(ent_reg.t0[0]));
            A_T1:    a_sel = AW'($signed(ent_reg.t0[1]));
            A_T2:    a_sel = AW'($signed(ent_reg.t0[2]));
            A_P0:    a_sel = AW'($signed(p_reg[0]));
            A_P1:    a_sel = AW'($signed(p_reg[1]));
            A_P2:    a_sel = AW'($signed(p_reg[2]));
            A_Q0:    a_sel = AW'($signed(q_reg[0]));
            A_Q1:    a_sel = AW'($signed(q_reg[1]));
            default: a_sel = AW'($signed(q_reg[2]));
        endcase
        case (op.bsel)
            B_E1_0:  b_sel = BW'($signed(ent_reg.e1[0]));
            B_E1_1:  b_sel = BW'($signed(ent_reg.e1[1]));
            B_E1_2:  b_sel = BW'($signed(ent_reg.e1[2]));
            B_E2_0:  b_sel = BW'($signed(ent_reg.e2[0]));
            B_E2_1:  b_sel = BW'($signed(ent_reg.e2[1]));
            B_E2_2:  b_sel = BW'($signed(ent_reg.e2[2]));
            B_T0:    b_sel = BW'($signed(ent_reg.t0[0]));
            B_T1:    b_sel = BW'($signed(ent_reg.t0[1]));
            B_T2:    b_sel = BW'($signed(ent_reg.t0[2]));
            B_D0:    b_sel = BW'($signed(ray.dir[0]));
            B_D1:    b_sel = BW'($signed(ray.dir[1]));
            default: b_sel = BW'($signed(ray.dir[2]));
        endcase
    end

    // inside test on normalised values, all non-negative except the sign checks
    assign accept_tri = (dd_reg != '0) && !uu_reg[ACCW-1] && (uu_reg <= dd_reg) &&
                        !vv_reg[ACCW-1] && ((uu_reg + vv_reg) <= dd_reg) &&
                        !tt_reg[ACCW-1] && (tt_reg != '0);

    assign better = !div_res.ovf && (div_res.quo <= ray.max_dist) &&
                    ({1'b0, div_res.quo} < best_reg);

    // round half up, add origin, clamp to the coordinate range
    always_comb
    begin
        rnd  = SUMW'(prod_reg) + (SUMW'(1) << (DIR_FRAC - 1));
        hsum = SUMW'($signed(rnd) >>> DIR_FRAC) + SUMW'($signed(ray.org[k_reg]));
        if (!hsum[SUMW-1] && (|hsum[SUMW-2:COORD_WIDTH-1]))
        begin
            hsat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (hsum[SUMW-1] && !(&hsum[SUMW-2:COORD_WIDTH-1]))
        begin
            hsat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            hsat = hsum[COORD_WIDTH-1:0];
        end
    end

    nrth_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .a     (a_sel),
        .b     (b_sel),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    nrth_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_req_go),
        .num   (tt_reg),
        .den   (dd_reg),
        .res   (div_res)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_head;
        end
        if ((state_reg == S_WAIT) && !mac_busy && op.last)
        begin
            case (op.dst)
                DST_P0:  p_reg[0] <= mac_acc[PW-1:0];
                DST_P1:  p_reg[1] <= mac_acc[PW-1:0];
                DST_P2:  p_reg[2] <= mac_acc[PW-1:0];
                DST_Q0:  q_reg[0] <= mac_acc[QW-1:0];
                DST_Q1:  q_reg[1] <= mac_acc[QW-1:0];
                DST_Q2:  q_reg[2] <= mac_acc[QW-1:0];
                DST_D:   dd_reg   <= mac_acc;
                DST_U:   uu_reg   <= mac_acc;
                DST_V:   vv_reg   <= mac_acc;
                default: tt_reg   <= mac_acc;
            endcase
        end
        if ((state_reg == S_NORM) && dd_reg[ACCW-1])
        begin
            dd_reg <= ~dd_reg + ACCW'(1);
            uu_reg <= ~uu_reg + ACCW'(1);
            vv_reg <= ~vv_reg + ACCW'(1);
            tt_reg <= ~tt_reg + ACCW'(1);
        end
        if (state_reg == S_HMUL)
        begin
            prod_reg <= $signed(ray.dir[k_reg]) * $signed({1'b0, best_reg[QB-1:0]});
        end
        if (state_reg == S_HADD)
        begin
            hv_reg[k_reg] <= hsat;
        end
        if (res_load)
        begin
            res_reg.hit   <= found_reg;
            res_reg.hit_x <= found_reg ? hv_reg[0] : '0;
            res_reg.hit_y <= found_reg ? hv_reg[1] : '0;
            res_reg.hit_z <= found_reg ? hv_reg[2] : '0;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            best_reg      <= '1;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !res_stall && !res_load)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!mac_busy)
                    begin
                        if (step_reg == STEP_W'(NSTEP - 1))
                        begin
                            state_reg <= S_NORM;
                        end
                        else
                        begin
                            step_reg  <= step_reg + STEP_W'(1);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_NORM:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    k_reg <= '0;
                    if (accept_tri)
                    begin
                        state_reg <= S_DIVGO;
                    end
                    else
                    begin
                        state_reg <= ent_reg.last ? S_HMUL : S_IDLE;
                    end
                end
                S_DIVGO:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (!div_res.busy)
                    begin
                        if (better)
                        begin
                            best_reg  <= {1'b0, div_res.quo};
                            found_reg <= 1'b1;
                        end
                        state_reg <= ent_reg.last ? S_HMUL : S_IDLE;
                    end
                end
                S_HMUL:
                begin
                    state_reg <= S_HADD;
                end
                S_HADD:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_HMUL;
                    end
                end
                S_EMIT:
                begin
                    if (res_free)
                    begin
                        res_valid_reg <= 1'b1;
                        best_reg      <= '1;
                        found_reg     <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `NRTH_ASSERT_IMP(a_res_load_free, res_load, !res_valid_reg || !res_stall, "result overwritten while held")
    `NRTH_ASSERT_IMP(a_pop_has_entry, q_pop, q_valid, "pop from empty queue")
    `NRTH_ASSERT_IMP(a_div_go_idle, div_req_go, !div_res.busy, "divider started while busy")
    `NRTH_ASSERT_NXT(a_clear_after_emit, res_load, !found_reg && res_valid_reg, "search not cleared")

endmodule

/* rtl/nearest_ray_triangle_hit.sv */
// top level of the nearest ray/triangle hit block: ray registers, front and back ends
//
//  channel  handshake               payload           direction
//  tri      tri_valid / tri_stall   tri_data (tri_t)  triangle requests in
//  res      res_valid / res_stall   res_data (res_t)  one result per query out
//  cfg      cfg_valid / cfg_ready   cfg_index, data   ray register writes in
//
// a rejected triangle skips the divider in the back end, an accepted one runs it:
// the shared multiply-accumulate unit works 24 product terms one 17-bit digit a cycle,
// and the divider yields one distance bit a cycle; the last triangle also computes the hit point
// reset clears queue pointers, sequencer, best distance and found flag at once, no sweep
// a two-entry queue sits between front and back, so triangles keep arriving, until it is full, while
// the back end works or while a finished result waits in the output register
module nearest_ray_triangle_hit
    import nrth_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tri_valid,
    output logic                   tri_stall,
    input  tri_t                   tri_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IW-1:0]      cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    ray_t  ray_reg;
    logic  q_valid;
    qent_t q_head;
    logic  q_pop;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg.org      <= '0;
            ray_reg.dir[0]   <= DIR_WIDTH'(1) << DIR_FRAC;
            ray_reg.dir[1]   <= '0;
            ray_reg.dir[2]   <= '0;
            ray_reg.max_dist <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: ray_reg.org[0]   <= cfg_data;
                REG_ORIGIN_Y: ray_reg.org[1]   <= cfg_data;
                REG_ORIGIN_Z: ray_reg.org[2]   <= cfg_data;
                REG_DIR_X:    ray_reg.dir[0]   <= cfg_data[DIR_WIDTH-1:0];
                REG_DIR_Y:    ray_reg.dir[1]   <= cfg_data[DIR_WIDTH-1:0];
                REG_DIR_Z:    ray_reg.dir[2]   <= cfg_data[DIR_WIDTH-1:0];
                REG_MAX_DIST: ray_reg.max_dist <= cfg_data[QB-1:0];
                default:      ray_reg.max_dist <= ray_reg.max_dist;
            endcase
        end
    end

    // front: edge vectors formed on acceptance, queued for the back end
    nrth_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .tri_data  (tri_data),
        .ray       (ray_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    // back: exact intersection test, distance division, nearest hit and result
    nrth_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
